// ----- hdl/fht_pkg.sv -----
// Package for the flow hash table lookup block: sizes, payload structs,
// sequencer states and the hash unit control bundle. No dependencies.
package fht_pkg;

  localparam int unsigned POOL_ENTRIES = 4096;
  localparam int unsigned ENTRY_BITS   = 12;
  localparam int unsigned BUCKET_BITS  = 12;
  localparam int unsigned BUCKET_COUNT = 1 << BUCKET_BITS;
  localparam int unsigned KEY_BYTES    = 64;
  localparam int unsigned KEY_WORDS    = 8;
  localparam int unsigned WORD_BITS    = 3;
  localparam int unsigned WALK_LIMIT   = 10000;
  localparam int unsigned STEP_BITS    = $clog2(WALK_LIMIT + 1);

  typedef struct packed {
    logic [63:0] basic_key_word;
    logic [63:0] full_key_word;
    logic [2:0]  word_index;
    logic [31:0] flow_type;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [11:0] flow_id;
    logic        is_new;
    logic        table_full;
    logic [31:0] packet_count;
    logic [47:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic seed_en;
  } hash_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_HEAD_LD,
    ST_CHECK,
    ST_KEY_RD,
    ST_KEY_CMP,
    ST_LINK_RD,
    ST_LINK_LD,
    ST_CNT_RD,
    ST_CNT_UPD,
    ST_MISS,
    ST_ALLOC,
    ST_LINK_WR,
    ST_OUT
  } state_e;

  // Bytes of key word w that lie inside the key.
  function automatic logic [63:0] word_mask(logic [WORD_BITS-1:0] w);
    logic [63:0] m;
    m = '0;
    for (int j = 0; j < 8; j++) begin
      if ((int'(w) * 8 + j) < int'(KEY_BYTES)) m[j*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ----- hdl/fht_hash_unit.sv -----
// Byte-serial hash unit: rotate-left-5 then XOR, one byte per cycle.
// Depends on fht_pkg.
module fht_hash_unit import fht_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hash_ctl_t            ctl_i,
  input  logic [31:0]          seed_i,
  input  logic [63:0]          word_i,
  input  logic [WORD_BITS-1:0] word_index_i,
  output logic                 done_o,
  output logic [31:0]          hash_o
);

  logic [31:0]          acc_q, acc_d;
  logic [63:0]          word_q;
  logic [WORD_BITS-1:0] widx_q;
  logic [2:0]           cnt_q;
  logic                 busy_q;
  logic [6:0]           byte_pos;

  assign byte_pos = {1'b0, widx_q, cnt_q};
  assign done_o   = busy_q && (cnt_q == 3'd7);
  assign hash_o   = acc_q;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.start && ctl_i.seed_en) begin
      acc_d = seed_i;
    end else if (busy_q && (byte_pos < 7'(KEY_BYTES))) begin
      acc_d = {acc_q[26:0], acc_q[31:27]} ^ {24'd0, word_q[7:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      acc_q <= acc_d;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      word_q <= word_i;
      widx_q <= word_index_i;
    end else if (busy_q) begin
      word_q <= {8'd0, word_q[63:8]};
    end
  end

endmodule

// ----- hdl/flow_hash_table_lookup.sv -----
// Flow hash table lookup, top level: sequencer, pool memories, result register.
// Depends on fht_pkg and fht_hash_unit.
//
// Each input transaction carries one 8-byte word of both keys. The shared
// hash unit folds the selected word in byte by byte, and ready returns only
// once it is done. The transaction with word index 7 then starts the chain
// walk: ST_HEAD and ST_HEAD_LD read the bucket head, then per visited entry
// one ST_CHECK step, a key compare of one key-memory read and one compare per
// word, stopping at the first mismatch, and ST_LINK_RD and ST_LINK_LD to
// follow the link. A walk that ends without a match passes ST_CHECK once
// more. A hit updates the counters in ST_CNT_RD and ST_CNT_UPD; a miss is
// decided in ST_MISS, then the key is copied into the pool word by word in
// ST_ALLOC and the entry linked in ST_LINK_WR (a full pool skips both). The
// result then sits in the output register until taken; no new transaction
// is taken meanwhile. After reset the block sweeps the 4096 bucket heads to
// empty, one per cycle, and stays not ready during the sweep; the mode
// register can be written at any time.
module flow_hash_table_lookup import fht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  state_e state_q, state_d;

  logic mode_q;           // full_key_mode register
  logic cmp_mode_q;       // mode at the last word of the packet
  logic in_accept;

  // pending key words of the current packet
  logic [63:0] pend_basic_q [KEY_WORDS];
  logic [63:0] pend_full_q  [KEY_WORDS];

  logic [WORD_BITS-1:0]   widx_q;
  logic [15:0]            len_q;
  logic [BUCKET_BITS-1:0] bucket_q;
  logic [BUCKET_BITS-1:0] clr_q;
  logic [ENTRY_BITS-1:0]  cur_q, head_q;
  logic [ENTRY_BITS:0]    next_free_q;
  logic [STEP_BITS-1:0]   steps_q;
  logic [WORD_BITS-1:0]   kw_q;
  out_item_t              out_q;

  // hash unit
  hash_ctl_t   hash_ctl;
  logic        hash_done;
  logic [31:0] hash_val;

  // memory controls
  logic head_we, head_re, key_we, key_re, link_we, link_re, cnt_we, cnt_re;
  logic [BUCKET_BITS-1:0] head_waddr;
  logic [ENTRY_BITS-1:0]  head_wdata;
  logic [31:0]            pkt_wdata;
  logic [47:0]            byte_wdata;

  logic [ENTRY_BITS-1:0] heads_mem [BUCKET_COUNT];
  logic [63:0] key_basic_mem [POOL_ENTRIES*KEY_WORDS];
  logic [63:0] key_full_mem  [POOL_ENTRIES*KEY_WORDS];
  logic [ENTRY_BITS-1:0] link_mem [POOL_ENTRIES];
  logic [31:0] pkt_mem  [POOL_ENTRIES];
  logic [47:0] byte_mem [POOL_ENTRIES];

  logic [ENTRY_BITS-1:0] head_rdata_q, link_rdata_q;
  logic [63:0] key_basic_rdata_q, key_full_rdata_q;
  logic [31:0] pkt_rdata_q;
  logic [47:0] byte_rdata_q;

  logic [ENTRY_BITS+WORD_BITS-1:0] key_addr;
  logic [63:0] key_mask, key_stored, key_want;
  logic        key_eq;
  logic        pool_full;

  assign in_accept  = in_valid_i && in_ready_o;
  assign key_addr   = {cur_q, kw_q};
  assign key_mask   = word_mask(kw_q);
  assign key_stored = cmp_mode_q ? key_full_rdata_q : key_basic_rdata_q;
  assign key_want   = cmp_mode_q ? pend_full_q[kw_q] : pend_basic_q[kw_q];
  assign key_eq     = (key_stored & key_mask) == (key_want & key_mask);
  assign pool_full  = next_free_q == (ENTRY_BITS+1)'(POOL_ENTRIES);

  fht_hash_unit u_hash (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (hash_ctl),
    .seed_i       (in_data_i.flow_type),
    .word_i       (mode_q ? in_data_i.full_key_word : in_data_i.basic_key_word),
    .word_index_i (in_data_i.word_index),
    .done_o       (hash_done),
    .hash_o       (hash_val)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:    if (in_accept) state_d = ST_HASH;
      ST_HASH: begin
        if (hash_done) state_d = (widx_q == '1) ? ST_HEAD : ST_IDLE;
      end
      ST_HEAD:    state_d = ST_HEAD_LD;
      ST_HEAD_LD: state_d = ST_CHECK;
      ST_CHECK: begin
        if ((cur_q == '0) || (steps_q == STEP_BITS'(WALK_LIMIT))) state_d = ST_MISS;
        else state_d = ST_KEY_RD;
      end
      ST_KEY_RD:  state_d = ST_KEY_CMP;
      ST_KEY_CMP: begin
        if (!key_eq) state_d = ST_LINK_RD;
        else if (kw_q == '1) state_d = ST_CNT_RD;
        else state_d = ST_KEY_RD;
      end
      ST_LINK_RD: state_d = ST_LINK_LD;
      ST_LINK_LD: state_d = ST_CHECK;
      ST_CNT_RD:  state_d = ST_CNT_UPD;
      ST_CNT_UPD: state_d = ST_OUT;
      ST_MISS:    state_d = pool_full ? ST_OUT : ST_ALLOC;
      ST_ALLOC:   if (kw_q == '1) state_d = ST_LINK_WR;
      ST_LINK_WR: state_d = ST_OUT;
      ST_OUT:     if (out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    hash_ctl.start   = 1'b0;
    hash_ctl.seed_en = 1'b0;
    head_we    = 1'b0;
    head_waddr = bucket_q;
    head_wdata = cur_q;
    head_re    = 1'b0;
    key_we     = 1'b0;
    key_re     = 1'b0;
    link_we    = 1'b0;
    link_re    = 1'b0;
    cnt_we     = 1'b0;
    cnt_re     = 1'b0;
    pkt_wdata  = pkt_rdata_q + 32'd1;
    byte_wdata = byte_rdata_q + {32'd0, len_q};
    unique case (state_q)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = '0;
      end
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        hash_ctl.start   = in_valid_i;
        hash_ctl.seed_en = in_valid_i && (in_data_i.word_index == '0);
      end
      ST_HEAD:    head_re = 1'b1;
      ST_KEY_RD:  key_re  = 1'b1;
      ST_LINK_RD: link_re = 1'b1;
      ST_CNT_RD:  cnt_re  = 1'b1;
      ST_CNT_UPD: cnt_we  = 1'b1;
      ST_ALLOC:   key_we  = 1'b1;
      ST_LINK_WR: begin
        head_we    = 1'b1;
        link_we    = 1'b1;
        cnt_we     = 1'b1;
        pkt_wdata  = 32'd1;
        byte_wdata = {32'd0, len_q};
      end
      ST_OUT:     out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign out_data_o = out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mode_q      <= 1'b0;
      clr_q       <= '0;
      next_free_q <= (ENTRY_BITS+1)'(1);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + BUCKET_BITS'(1);
      if (state_q == ST_LINK_WR) next_free_q <= next_free_q + (ENTRY_BITS+1)'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_basic_q[in_data_i.word_index] <= in_data_i.basic_key_word;
      pend_full_q[in_data_i.word_index]  <= in_data_i.full_key_word;
      widx_q     <= in_data_i.word_index;
      len_q      <= in_data_i.packet_length;
      cmp_mode_q <= mode_q;
    end
    unique case (state_q)
      ST_HEAD:    bucket_q <= hash_val[BUCKET_BITS-1:0];
      ST_HEAD_LD: begin
        cur_q   <= head_rdata_q;
        head_q  <= head_rdata_q;
        steps_q <= '0;
      end
      ST_CHECK:   kw_q <= '0;
      ST_KEY_CMP: kw_q <= kw_q + WORD_BITS'(1);
      ST_LINK_LD: begin
        cur_q   <= link_rdata_q;
        steps_q <= steps_q + STEP_BITS'(1);
      end
      ST_CNT_UPD: begin
        out_q.flow_id      <= cur_q;
        out_q.is_new       <= 1'b0;
        out_q.table_full   <= 1'b0;
        out_q.packet_count <= pkt_wdata;
        out_q.byte_count   <= byte_wdata;
      end
      ST_MISS: begin
        cur_q <= next_free_q[ENTRY_BITS-1:0];
        kw_q  <= '0;
        // full pool: no state changes, result zero but for table_full
        out_q <= '{flow_id: '0, is_new: 1'b0, table_full: 1'b1,
                   packet_count: '0, byte_count: '0};
      end
      ST_ALLOC:   kw_q <= kw_q + WORD_BITS'(1);
      ST_LINK_WR: begin
        out_q.flow_id      <= cur_q;
        out_q.is_new       <= 1'b1;
        out_q.table_full   <= 1'b0;
        out_q.packet_count <= pkt_wdata;
        out_q.byte_count   <= byte_wdata;
      end
      default: ;
    endcase
  end

  // bucket heads
  always_ff @(posedge clk_i) begin
    if (head_we) heads_mem[head_waddr] <= head_wdata;
    if (head_re) head_rdata_q <= heads_mem[hash_val[BUCKET_BITS-1:0]];
  end

  // entry keys, both kinds stored on allocation
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_basic_mem[key_addr] <= pend_basic_q[kw_q];
      key_full_mem[key_addr]  <= pend_full_q[kw_q];
    end
    if (key_re) begin
      key_basic_rdata_q <= key_basic_mem[key_addr];
      key_full_rdata_q  <= key_full_mem[key_addr];
    end
  end

  // chain links
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[cur_q] <= head_q;
    if (link_re) link_rdata_q <= link_mem[cur_q];
  end

  // per-flow counters
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      pkt_mem[cur_q]  <= pkt_wdata;
      byte_mem[cur_q] <= byte_wdata;
    end
    if (cnt_re) begin
      pkt_rdata_q  <= pkt_mem[cur_q];
      byte_rdata_q <= byte_mem[cur_q];
    end
  end

endmodule

// ----- hdl/fht_checker.sv -----
// Port-level checks for flow_hash_table_lookup, attached by bind.
// Depends on fht_pkg.
module fht_sva import fht_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // one packet word at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after input transaction");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready while a result is pending");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.table_full |-> !out_data_o.is_new &&
      (out_data_o.flow_id == '0) && (out_data_o.packet_count == '0) &&
      (out_data_o.byte_count == '0))
    else $error("full-pool result not zero");

  a_new_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_new |-> (out_data_o.packet_count == 32'd1) &&
      (out_data_o.flow_id != '0))
    else $error("new flow with bad count or id");

endmodule

bind flow_hash_table_lookup fht_sva u_fht_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- tb/fht_checker.sv -----
// Checker for the flow hash table lookup: watches the input, output and mode
// ports, predicts every result and compares it. Depends on fht_pkg.
module fht_checker import fht_pkg::*; (
  input  logic      clk_i,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic        mode_q = 1'b0;
  logic [31:0] hash_acc = '0;
  logic [63:0] pend_basic [KEY_WORDS];
  logic [63:0] pend_full  [KEY_WORDS];
  logic [11:0] heads      [BUCKET_COUNT];
  logic [63:0] pool_basic [POOL_ENTRIES][KEY_WORDS];
  logic [63:0] pool_full  [POOL_ENTRIES][KEY_WORDS];
  logic [11:0] pool_link  [POOL_ENTRIES];
  logic [31:0] pool_pkts  [POOL_ENTRIES];
  logic [47:0] pool_bytes [POOL_ENTRIES];
  int unsigned next_free = 1;
  out_item_t   flow_results_q [$];
  int          mismatches = 0;

  initial begin
    foreach (heads[i]) heads[i] = '0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [31:0] fold_word(logic [31:0] h, logic [63:0] word);
    for (int j = 0; j < 8; j++) h = {h[26:0], h[31:27]} ^ {24'd0, word[j*8 +: 8]};
    return h;
  endfunction

  function automatic logic key_equal(int unsigned e, logic full);
    for (int w = 0; w < KEY_WORDS; w++) begin
      if (full ? (pool_full[e][w] != pend_full[w]) : (pool_basic[e][w] != pend_basic[w]))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // Chain walk, allocation on miss, counter update.
  function automatic out_item_t lookup_flow(logic [15:0] len);
    out_item_t   r;
    logic [11:0] bkt;
    int unsigned cur, e;
    int          steps;
    logic        hit;
    r   = '0;
    bkt = hash_acc[BUCKET_BITS-1:0];
    cur = 32'(heads[bkt]);
    hit = 1'b0;
    e   = 0;
    steps = 0;
    while (!hit && cur != 0 && steps < WALK_LIMIT) begin
      if (key_equal(cur, mode_q)) begin
        hit = 1'b1;
        e   = cur;
      end else begin
        cur = 32'(pool_link[cur]);
      end
      steps++;
    end
    if (!hit) begin
      if (next_free >= POOL_ENTRIES) begin
        r.table_full = 1'b1;
        return r;
      end
      e = next_free;
      next_free++;
      for (int k = 0; k < KEY_WORDS; k++) begin
        pool_basic[e][k] = pend_basic[k];
        pool_full[e][k]  = pend_full[k];
      end
      pool_link[e]  = heads[bkt];
      heads[bkt]    = e[11:0];
      pool_pkts[e]  = '0;
      pool_bytes[e] = '0;
    end
    pool_pkts[e]   = pool_pkts[e] + 32'd1;
    pool_bytes[e]  = pool_bytes[e] + {32'd0, len};
    r.flow_id      = e[11:0];
    r.is_new       = !hit;
    r.packet_count = pool_pkts[e];
    r.byte_count   = pool_bytes[e];
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (cfg_we_i) mode_q <= cfg_wdata_i;
    if (in_valid_i && in_ready_i) begin
      if (in_data_i.word_index == 3'd0) hash_acc = in_data_i.flow_type;
      hash_acc = fold_word(hash_acc, mode_q ? in_data_i.full_key_word
                                            : in_data_i.basic_key_word);
      pend_basic[in_data_i.word_index] = in_data_i.basic_key_word;
      pend_full[in_data_i.word_index]  = in_data_i.full_key_word;
      if (in_data_i.word_index == 3'd7)
        flow_results_q.push_back(lookup_flow(in_data_i.packet_length));
    end
    if (out_valid_i && out_ready_i) begin
      if (flow_results_q.size() == 0) begin
        fail_count_o <= fail_count_o + 1;
        if (mismatches < 10) $display("unexpected result %p", out_data_i);
        mismatches++;
      end else begin
        exp_r = flow_results_q.pop_front();
        if (exp_r.flow_id != out_data_i.flow_id || exp_r.is_new != out_data_i.is_new ||
            exp_r.table_full != out_data_i.table_full ||
            exp_r.packet_count != out_data_i.packet_count ||
            exp_r.byte_count != out_data_i.byte_count) begin
          fail_count_o <= fail_count_o + 1;
          if (mismatches < 10) $display("mismatch: expected %p actual %p", exp_r, out_data_i);
          mismatches++;
        end
      end
    end
    pending_o <= flow_results_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for flow_hash_table_lookup: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Depends on fht_pkg and fht_checker.
module tb;
  import fht_pkg::*;

  localparam int STALL_LIMIT = 20000; // covers the head sweep after reset

  typedef struct {
    logic [63:0] basic [KEY_WORDS];
    logic [63:0] full  [KEY_WORDS];
    logic [31:0] ftype;
  } flow_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  int        fail_count, pending;

  logic      hold_go = 1'b0;   // one-cycle request for a long receiver hold-off
  int        hold_left = 0;
  int        rx_cycle = 0;
  int        burst_left = 0;
  logic      no_gaps = 1'b0;
  int        idle_cycles = 0;
  flow_t     known_flows [$];

  always #2 clk_i = ~clk_i;

  flow_hash_table_lookup i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  fht_checker i_checker (
    .clk_i       (clk_i),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Receiver: fixed stall pattern repeating over rx_cycle[3:0], fully open while rx_cycle[9]
  // is set, and a long hold-off on request so the block backs up.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_go) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    out_ready <= !hold_go && (hold_left <= 1) &&
                 (rx_cycle[9] || 16'b1011_1110_0111_1101 >> rx_cycle[3:0] & 1'b1);
  end

  // Watchdog: cycles without any transaction on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic flow_t random_flow();
    flow_t f;
    for (int w = 0; w < KEY_WORDS; w++) begin
      f.basic[w] = rand64();
      f.full[w]  = rand64();
    end
    f.ftype = $urandom;
    return f;
  endfunction

  // Offer one transaction; returns in the time step of its acceptance.
  task automatic send_word(in_item_t item);
    int gap;
    if (burst_left == 0 && !no_gaps) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_packet(flow_t f, logic [15:0] len, logic shuffle,
                             int first = 0, int last = 7);
    in_item_t it;
    int       order [8];
    int       j, t;
    for (int k = 0; k < 8; k++) order[k] = k;
    if (shuffle) begin
      for (int k = 6; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = order[k]; order[k] = order[j]; order[j] = t;
      end
    end
    for (int k = first; k <= last; k++) begin
      it.basic_key_word = f.basic[order[k]];
      it.full_key_word  = f.full[order[k]];
      it.word_index     = order[k][2:0];
      it.flow_type      = f.ftype;
      it.packet_length  = len;
      send_word(it);
    end
  endtask

  // Drop valid and wait until the block has drained.
  task automatic go_quiet();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    go_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  // Mostly whole packets of known flows (hits) and fresh flows, the rest
  // stray single words in any position.
  task automatic random_traffic(int n_items);
    int       sent, sel;
    flow_t    f;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        it.basic_key_word = rand64();
        it.full_key_word  = rand64();
        it.word_index     = 3'($urandom_range(0, 7));
        it.flow_type      = $urandom;
        it.packet_length  = 16'($urandom);
        send_word(it);
        sent++;
      end else begin
        if (sel < 65 && known_flows.size() > 0) begin
          f = known_flows[$urandom_range(0, known_flows.size() - 1)];
        end else begin
          f = random_flow();
          if (known_flows.size() < 32) known_flows.push_back(f);
          else known_flows[$urandom_range(0, 31)] = f;
        end
        send_packet(f, 16'($urandom), $urandom_range(0, 3) == 0);
        sent += 8;
      end
      if (sent > 200 && sent < 216 && !hold_go && hold_left == 0 && n_items > 400) begin
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
    end
  endtask

  initial begin
    flow_t zero_f, ones_f, mix_f;
    for (int w = 0; w < KEY_WORDS; w++) begin
      zero_f.basic[w] = '0;
      zero_f.full[w]  = '0;
      ones_f.basic[w] = '1;
      ones_f.full[w]  = '1;
    end
    zero_f.ftype = '0;
    ones_f.ftype = '1;
    mix_f = random_flow();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: key extremes, a repeat hit, words out of order, and a mode
    // change halfway through a packet.
    send_packet(zero_f, 16'd0, 1'b0);
    send_packet(ones_f, 16'hffff, 1'b0);
    send_packet(ones_f, 16'hffff, 1'b1);
    write_mode(1'b1);
    send_packet(mix_f, 16'd1500, 1'b0, 0, 3);
    write_mode(1'b0);
    send_packet(mix_f, 16'd64, 1'b0, 4, 7);

    write_mode(1'b1);
    random_traffic(500);
    go_quiet();            // sender pause until every result is back
    write_mode(1'b0);
    random_traffic(550);

    // Revisit a few known flows back to back in extended-key mode.
    write_mode(1'b1);
    no_gaps = 1'b1;
    for (int p = 0; p < 8; p++)
      send_packet(known_flows[$urandom_range(0, known_flows.size() - 1)],
                  16'($urandom), 1'b0);
    no_gaps = 1'b0;

    go_quiet();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
